FILE: hw/rtl/scx_pkg.sv
// Shared widths and controller/datapath handshake types for the sysex codec.
// No dependencies; compile first.
package scx_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned LOW_W  = 7;
  localparam int unsigned CNT_W  = 3;

  typedef struct packed {
    logic accept;     // take the input item this cycle
    logic emit_hdr;   // load the pack header into the output register
    logic emit_data;  // load the next drained group byte
  } scx_cmd_t;

  typedef struct packed {
    logic emit_now;   // accepted item yields one result directly (unpack)
    logic flush;      // accepted item closes a pack group
    logic drain_done; // current drain byte is the last of the group
  } scx_sts_t;

endpackage

FILE: hw/rtl/scx_ifs.sv
// Valid/ready channel interfaces for input items, results and configuration.
// Depends on scx_pkg for widths.
interface scx_in_if;
  logic                       valid;
  logic                       ready;
  logic [scx_pkg::DATA_W-1:0] in_byte;
  logic                       last_in;
  modport source (output valid, in_byte, last_in, input ready);
  modport sink   (input valid, in_byte, last_in, output ready);
endinterface

interface scx_out_if;
  logic                       valid;
  logic                       ready;
  logic [scx_pkg::DATA_W-1:0] out_byte;
  logic                       byte_valid;
  logic                       last_out;
  modport source (output valid, out_byte, byte_valid, last_out, input ready);
  modport sink   (input valid, out_byte, byte_valid, last_out, output ready);
endinterface

interface scx_cfg_if;
  logic valid;
  logic ready;
  logic direction_mode;
  modport source (output valid, direction_mode, input ready);
  modport sink   (input valid, direction_mode, output ready);
endinterface

FILE: hw/rtl/scx_ctrl.sv
// Sequencing FSM of the sysex codec: input handshake, group drain, output valid.
// Depends on scx_pkg.
module scx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  scx_pkg::scx_sts_t sts_i,
  output scx_pkg::scx_cmd_t cmd_o
);
  import scx_pkg::*;

  typedef enum logic [1:0] {
    ST_IN,
    ST_HDR,
    ST_DATA
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   load;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.accept    = (state_q == ST_IN) && slot_free && in_valid_i;
    cmd_o.emit_hdr  = (state_q == ST_HDR) && slot_free;
    cmd_o.emit_data = (state_q == ST_DATA) && slot_free;
    load = (cmd_o.accept && sts_i.emit_now) || cmd_o.emit_hdr || cmd_o.emit_data;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    state_d = state_q;
    case (state_q)
      ST_IN: begin
        if (cmd_o.accept && sts_i.flush) state_d = ST_HDR;
      end
      ST_HDR: begin
        if (cmd_o.emit_hdr) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (cmd_o.emit_data && sts_i.drain_done) state_d = ST_IN;
      end
      default: state_d = ST_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IN) && slot_free;
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/scx_dp.sv
// Datapath of the sysex codec: group store, header, counters, output register.
// Depends on scx_pkg.
module scx_dp #(
  parameter int unsigned GROUP_SIZE = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [scx_pkg::DATA_W-1:0] in_byte_i,
  input  logic                       last_in_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_mode_i,
  input  scx_pkg::scx_cmd_t          cmd_i,
  output scx_pkg::scx_sts_t          sts_o,
  output logic [scx_pkg::DATA_W-1:0] out_byte_o,
  output logic                       byte_valid_o,
  output logic                       last_out_o
);
  import scx_pkg::*;

  logic [LOW_W-1:0] store_q [GROUP_SIZE];

  logic             mode_q;
  logic             expect_q;
  logic [LOW_W-1:0] header_q;
  logic [CNT_W-1:0] count_q;
  logic [LOW_W-1:0] flush_hdr_q;
  logic [CNT_W-1:0] drain_n_q;
  logic [CNT_W-1:0] rd_q;
  logic             flush_last_q;
  logic [DATA_W-1:0] out_byte_q;
  logic             byte_valid_q;
  logic             last_out_q;

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_inc;
  logic [LOW_W-1:0] hdr_set;
  logic             group_end;

  always_comb begin
    idx       = (count_q >= CNT_W'(GROUP_SIZE)) ? '0 : count_q;
    idx_inc   = idx + CNT_W'(1);
    hdr_set   = header_q | (LOW_W'(in_byte_i[DATA_W-1]) << idx);
    group_end = (idx_inc == CNT_W'(GROUP_SIZE)) || last_in_i;
    sts_o.emit_now   = mode_q && (!expect_q || last_in_i);
    sts_o.flush      = !mode_q && group_end;
    sts_o.drain_done = (rd_q == drain_n_q - CNT_W'(1));
  end

  // Group store has no reset: entries are always written before being drained.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !mode_q) begin
      store_q[idx] <= in_byte_i[LOW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      expect_q     <= 1'b1;
      header_q     <= '0;
      count_q      <= '0;
      flush_hdr_q  <= '0;
      drain_n_q    <= '0;
      rd_q         <= '0;
      flush_last_q <= 1'b0;
      out_byte_q   <= '0;
      byte_valid_q <= 1'b0;
      last_out_q   <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q   <= cfg_mode_i;
      expect_q <= 1'b1;
      header_q <= '0;
      count_q  <= '0;
    end else if (cmd_i.accept) begin
      if (mode_q) begin
        if (expect_q) begin
          count_q <= '0;
          if (last_in_i) begin
            // empty end marker
            header_q     <= '0;
            out_byte_q   <= '0;
            byte_valid_q <= 1'b0;
            last_out_q   <= 1'b1;
          end else begin
            header_q <= in_byte_i[LOW_W-1:0];
            expect_q <= 1'b0;
          end
        end else begin
          out_byte_q   <= {header_q[idx], in_byte_i[LOW_W-1:0]};
          byte_valid_q <= 1'b1;
          last_out_q   <= last_in_i;
          if (group_end) begin
            count_q  <= '0;
            expect_q <= 1'b1;
            if (last_in_i) header_q <= '0;
          end else begin
            count_q <= idx_inc;
          end
        end
      end else if (group_end) begin
        flush_hdr_q  <= hdr_set;
        header_q     <= '0;
        count_q      <= '0;
        drain_n_q    <= idx_inc;
        flush_last_q <= last_in_i;
        rd_q         <= '0;
      end else begin
        header_q <= hdr_set;
        count_q  <= idx_inc;
      end
    end else if (cmd_i.emit_hdr) begin
      out_byte_q   <= {1'b0, flush_hdr_q};
      byte_valid_q <= 1'b1;
      last_out_q   <= 1'b0;
      rd_q         <= '0;
    end else if (cmd_i.emit_data) begin
      out_byte_q   <= {1'b0, store_q[rd_q]};
      byte_valid_q <= 1'b1;
      last_out_q   <= flush_last_q && sts_o.drain_done;
      rd_q         <= rd_q + CNT_W'(1);
    end
  end

  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign last_out_o   = last_out_q;

endmodule

FILE: hw/rtl/sysex_seven_bit_codec.sv
// MIDI sysex 7-bit codec: packs raw bytes into header+7-bit groups or unpacks them.
// Unpack: one item per cycle while the output is free; a data result shows the cycle
// after acceptance. Pack: a closing byte holds off input while the header and its n
// bytes (n <= GROUP_SIZE) drain serially through the single output register.
// Reset: pack mode, awaiting header, empty group, no result pending; store contents
// are undefined and need no clearing pass.
module sysex_seven_bit_codec #(
  parameter int unsigned GROUP_SIZE = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  scx_in_if.sink    in_ch,
  scx_out_if.source out_ch,
  scx_cfg_if.sink   cfg_ch
);
  import scx_pkg::*;

  scx_cmd_t cmd;
  scx_sts_t sts;
  logic     cfg_we;

  // User writes configuration only while idle (unchecked here), so always take it.
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  // Sequence input acceptance, group drain and output valid.
  scx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold group bytes, header and counters; drive the result register.
  scx_dp #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_ch.in_byte),
    .last_in_i    (in_ch.last_in),
    .cfg_we_i     (cfg_we),
    .cfg_mode_i   (cfg_ch.direction_mode),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_byte_o   (out_ch.out_byte),
    .byte_valid_o (out_ch.byte_valid),
    .last_out_o   (out_ch.last_out)
  );

endmodule
